FILE: rtl/core/s20sc_pkg.sv
package s20sc_pkg;

  localparam int unsigned ROUNDS    = 20;
  localparam int unsigned ROT_A     = 7;
  localparam int unsigned ROT_B     = 9;
  localparam int unsigned ROT_C     = 13;
  localparam int unsigned ROT_D     = 18;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        end_of_message;
  } in_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [3:0]  bytes_out;
  } out_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
    logic [63:0]      counter;
  } blk_in_t;

  function automatic logic [31:0] rotl(logic [31:0] w, int unsigned n);
    return (w << n) | (w >> (32 - n));
  endfunction

  // v = {d, c, b, a}
  function automatic quad_t quarter(quad_t v);
    quad_t r;
    r = v;
    r[1] = r[1] ^ rotl(r[0] + r[3], ROT_A);
    r[2] = r[2] ^ rotl(r[1] + r[0], ROT_B);
    r[3] = r[3] ^ rotl(r[2] + r[1], ROT_C);
    r[0] = r[0] ^ rotl(r[3] + r[2], ROT_D);
    return r;
  endfunction

  function automatic state_t make_init(blk_in_t b);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = b.key[0][31:0];
    s[2]  = b.key[0][63:32];
    s[3]  = b.key[1][31:0];
    s[4]  = b.key[1][63:32];
    s[5]  = SIGMA1;
    s[6]  = b.nonce[31:0];
    s[7]  = b.nonce[63:32];
    s[8]  = b.counter[31:0];
    s[9]  = b.counter[63:32];
    s[10] = SIGMA2;
    s[11] = b.key[2][31:0];
    s[12] = b.key[2][63:32];
    s[13] = b.key[3][31:0];
    s[14] = b.key[3][63:32];
    s[15] = SIGMA3;
    return s;
  endfunction

endpackage

FILE: rtl/core/salsa20_stream_cipher.sv
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   in_data   (data_word, byte_count, end_of_message)
// out      out  out_valid/out_stall out_data  (data_out, bytes_out)
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item that finds unused keystream is written to the output register in the cycle it is accepted.
// An item that needs a fresh block goes through these steps: the transfer cycle loads the core, 20 round
// steps on the shared round unit (one column or row round per cycle), final add, handoff to the
// emit state, then emit once the output register is not held by out_stall.
// Synchronous active-low reset clears control state, key, nonce and counter.
// in_stall is high while a block is being built or emitted, or the output register is held by out_stall.
module salsa20_stream_cipher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  s20sc_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output s20sc_pkg::out_t                     out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [s20sc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                         cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GEN,
    S_EMIT
  } state_t;

  state_t             state_r;
  logic [3:0][63:0]   key_r;
  logic [63:0]        nonce_r;
  logic [63:0]        counter_r;
  logic [2:0]         pos_r;
  logic               ready_r;
  logic               out_valid_r;
  s20sc_pkg::out_t    out_r;
  s20sc_pkg::in_t     hold_r;

  s20sc_pkg::blk_in_t blk_in;
  s20sc_pkg::state_t  words;
  logic               core_done;
  logic               slot_free;
  logic               in_fire;
  logic               cfg_fire;
  logic               need_blk;
  logic               emit;
  s20sc_pkg::in_t     cur;
  logic [63:0]        ks_word;
  logic [3:0]         sat;
  logic               zero_cnt;
  s20sc_pkg::out_t    res;

  assign blk_in.key     = key_r;
  assign blk_in.nonce   = nonce_r;
  assign blk_in.counter = counter_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign need_blk  = !ready_r && (in_data.byte_count != 4'd0);

  assign cur     = (state_r == S_EMIT) ? hold_r : in_data;
  assign ks_word = {words[{pos_r, 1'b1}], words[{pos_r, 1'b0}]};
  assign emit    = (in_fire && !need_blk) || (state_r == S_EMIT && slot_free);

  s20sc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire && need_blk),
    .blk_in (blk_in),
    .done   (core_done),
    .words  (words)
  );

  always_comb begin
    zero_cnt = (cur.byte_count == 4'd0);
    sat      = (cur.byte_count > 4'd8) ? 4'd8 : cur.byte_count;
    res.bytes_out = sat;
    for (int i = 0; i < 8; i++) begin
      res.data_out[8*i +: 8] = (4'(i) < sat) ?
                               (cur.data_word[8*i +: 8] ^ ks_word[8*i +: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= '0;
      nonce_r     <= '0;
      counter_r   <= '0;
      pos_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
        if (zero_cnt || cur.end_of_message || sat != 4'd8) begin
          ready_r <= 1'b0;
          pos_r   <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
          if (pos_r == 3'd7) begin
            ready_r <= 1'b0;
          end
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && need_blk) begin
            hold_r  <= in_data;
            state_r <= S_GEN;
          end
        end
        S_GEN: begin
          if (core_done) begin
            counter_r <= counter_r + 64'd1;
            ready_r   <= 1'b1;
            pos_r     <= '0;
            state_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_fire) begin
        unique case (cfg_index) inside
          s20sc_pkg::REG_KEY0,
          s20sc_pkg::REG_KEY1,
          s20sc_pkg::REG_KEY2,
          s20sc_pkg::REG_KEY3: key_r[cfg_index[1:0]] <= cfg_data;
          s20sc_pkg::REG_NONCE: nonce_r <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= s20sc_pkg::REG_NONCE) begin
          counter_r <= '0;
          ready_r   <= 1'b0;
          pos_r     <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/s20sc_round.sv
module s20sc_round (
  input  s20sc_pkg::state_t st,
  input  logic              row,
  output s20sc_pkg::state_t nxt
);

  localparam logic [3:0] COL_IDX [4][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11}
  };
  localparam logic [3:0] ROW_IDX [4][4] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  always_comb begin
    s20sc_pkg::quad_t v;
    s20sc_pkg::quad_t r;
    logic [3:0]       idx [4];
    nxt = st;
    for (int q = 0; q < 4; q++) begin
      for (int k = 0; k < 4; k++) begin
        idx[k] = row ? ROW_IDX[q][k] : COL_IDX[q][k];
        v[k]   = st[idx[k]];
      end
      r = s20sc_pkg::quarter(v);
      for (int k = 0; k < 4; k++) begin
        nxt[idx[k]] = r[k];
      end
    end
  end

endmodule

FILE: rtl/core/s20sc_core.sv
module s20sc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  s20sc_pkg::blk_in_t blk_in,
  output logic               done,
  output s20sc_pkg::state_t  words
);

  localparam int unsigned RND_W    = $clog2(s20sc_pkg::ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(s20sc_pkg::ROUNDS - 1);

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_ADD
  } cstate_t;

  cstate_t           st_r;
  logic [RND_W-1:0]  rnd_r;
  logic              done_r;
  s20sc_pkg::state_t x_r;
  s20sc_pkg::state_t init;
  s20sc_pkg::state_t rnd_out;

  assign init = s20sc_pkg::make_init(blk_in);

  // even steps are column rounds, odd steps row rounds
  s20sc_round u_round (
    .st  (x_r),
    .row (rnd_r[0]),
    .nxt (rnd_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        C_IDLE: begin
          if (start) begin
            x_r   <= init;
            rnd_r <= '0;
            st_r  <= C_RUN;
          end
        end
        C_RUN: begin
          x_r   <= rnd_out;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == RND_LAST) begin
            st_r <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 16; i++) begin
            x_r[i] <= x_r[i] + init[i];
          end
          done_r <= 1'b1;
          st_r   <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign words = x_r;

endmodule
